>>> src/roberts_cross_edge_marker_defines.svh
// Assertion macros shared by the checker of the edge marker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef ROBERTS_CROSS_EDGE_MARKER_DEFINES_SVH
`define ROBERTS_CROSS_EDGE_MARKER_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define RCEM_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define RCEM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/rcem_pkg.sv
// Shared types, constants and a helper function of the edge marker.
// No dependencies; used by every module of the block but rcem_ram.
package rcem_pkg;

  localparam int MAX_WIDTH   = 256;
  localparam int MAX_HEIGHT  = 256;
  localparam int COORD_W     = 8;
  localparam int CHAN_W      = 8;
  localparam int PIX_W       = 3 * CHAN_W;
  localparam int ADDR_W      = 2 * COORD_W;
  localparam int MEM_DEPTH   = MAX_WIDTH * MAX_HEIGHT;
  localparam int DIM_W       = 9;
  localparam int THR_W       = 19;
  localparam int SQ_W        = 2 * CHAN_W;
  localparam int NUM_SQ      = 6;
  localparam int NUM_CELLS   = 4;
  localparam int WIN_SIZE    = 9;
  localparam int CNT_W       = 4;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int CFG_IDX_W   = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH    = 2'd0,
    REG_FRAME_HEIGHT   = 2'd1,
    REG_EDGE_THRESHOLD = 2'd2
  } reg_idx_t;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_FETCH,
    B_ENERGY,
    B_RESULT
  } back_state_t;

  // One classified item as it waits between front and back.
  // cells flags which of the four touching cells lie inside the frame, in
  // the order (x-1,y-1), (x-1,y), (x,y-1), (x,y).
  typedef struct packed {
    op_t                      op;
    logic [COORD_W-1:0]       col;
    logic [COORD_W-1:0]       row;
    logic [PIX_W-1:0]         pixel;
    logic [NUM_CELLS-1:0]     cells;
  } cmd_t;

  function automatic logic [SQ_W-1:0] abs_sq(input logic [CHAN_W-1:0] a,
                                             input logic [CHAN_W-1:0] b);
    logic [CHAN_W-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return SQ_W'(d) * SQ_W'(d);
  endfunction

endpackage

>>> src/rcem_ram.sv
// Generic single-port RAM with a registered read.
// No dependencies; holds the frame store of the edge marker.
module rcem_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> src/rcem_front.sv
// Front end: configuration registers, input acceptance and classification.
// Depends on rcem_pkg; feeds rcem_queue and supplies the threshold to rcem_back.
module rcem_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rcem_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rcem_pkg::THR_W-1:0]    cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          kind,
  input  logic [rcem_pkg::COORD_W-1:0]  col,
  input  logic [rcem_pkg::COORD_W-1:0]  row,
  input  logic [rcem_pkg::CHAN_W-1:0]   red,
  input  logic [rcem_pkg::CHAN_W-1:0]   green,
  input  logic [rcem_pkg::CHAN_W-1:0]   blue,
  input  logic                          q_full,
  output logic                          q_push,
  output rcem_pkg::cmd_t                q_cmd,
  output logic [rcem_pkg::THR_W-1:0]    threshold
);

  logic [rcem_pkg::DIM_W-1:0] frame_width;
  logic [rcem_pkg::DIM_W-1:0] frame_height;
  logic [rcem_pkg::DIM_W-1:0] w_eff;
  logic [rcem_pkg::DIM_W-1:0] h_eff;
  logic [rcem_pkg::DIM_W-1:0] col_ext;
  logic [rcem_pkg::DIM_W-1:0] row_ext;
  logic                       x_lo_ok;
  logic                       x_hi_ok;
  logic                       y_lo_ok;
  logic                       y_hi_ok;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= rcem_pkg::DIM_W'(256);
      frame_height <= rcem_pkg::DIM_W'(256);
      threshold    <= rcem_pkg::THR_W'(2000);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rcem_pkg::REG_FRAME_WIDTH:    frame_width  <= cfg_data[rcem_pkg::DIM_W-1:0];
        rcem_pkg::REG_FRAME_HEIGHT:   frame_height <= cfg_data[rcem_pkg::DIM_W-1:0];
        rcem_pkg::REG_EDGE_THRESHOLD: threshold    <= cfg_data;
        default: ;
      endcase
    end
  end

  // The frame in use never reaches past the store.
  assign w_eff = (frame_width > rcem_pkg::DIM_W'(rcem_pkg::MAX_WIDTH)) ?
                 rcem_pkg::DIM_W'(rcem_pkg::MAX_WIDTH) : frame_width;
  assign h_eff = (frame_height > rcem_pkg::DIM_W'(rcem_pkg::MAX_HEIGHT)) ?
                 rcem_pkg::DIM_W'(rcem_pkg::MAX_HEIGHT) : frame_height;

  assign col_ext = rcem_pkg::DIM_W'(col);
  assign row_ext = rcem_pkg::DIM_W'(row);

  // A cell at column cx exists when cx+1 < width; for cx = x-1 that is x < width.
  assign x_lo_ok = (col != '0) && (col_ext < w_eff);
  assign x_hi_ok = (col_ext + rcem_pkg::DIM_W'(1)) < w_eff;
  assign y_lo_ok = (row != '0) && (row_ext < h_eff);
  assign y_hi_ok = (row_ext + rcem_pkg::DIM_W'(1)) < h_eff;

  assign in_stall = q_full;
  assign q_push   = in_valid && !in_stall;

  always_comb begin
    q_cmd.op    = rcem_pkg::op_t'(kind);
    q_cmd.col   = col;
    q_cmd.row   = row;
    q_cmd.pixel = {red, green, blue};
    q_cmd.cells = {x_hi_ok && y_hi_ok, x_hi_ok && y_lo_ok,
                   x_lo_ok && y_hi_ok, x_lo_ok && y_lo_ok};
  end

endmodule

>>> src/rcem_queue.sv
// Short command queue that decouples the front end from the back end.
// Depends on rcem_pkg for the command type and depth.
module rcem_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  rcem_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output rcem_pkg::cmd_t head
);

  rcem_pkg::cmd_t                entries [rcem_pkg::QUEUE_DEPTH];
  logic [rcem_pkg::QPTR_W-1:0]   wr_ptr;
  logic [rcem_pkg::QPTR_W-1:0]   rd_ptr;
  logic [rcem_pkg::QPTR_W:0]     count;
  logic                          do_pop;

  assign full       = (count == (rcem_pkg::QPTR_W+1)'(rcem_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + rcem_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + rcem_pkg::QPTR_W'(1);
      end
      if (push && !do_pop) begin
        count <= count + (rcem_pkg::QPTR_W+1)'(1);
      end else if (do_pop && !push) begin
        count <= count - (rcem_pkg::QPTR_W+1)'(1);
      end
    end
  end

endmodule

>>> src/rcem_back.sv
// Back end: stores pixels, fetches the 3x3 neighborhood of a query and
// evaluates the four Roberts-cross cells. Depends on rcem_pkg; drives the
// frame RAM and the result register.
module rcem_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_valid,
  input  rcem_pkg::cmd_t               q_head,
  output logic                         q_pop,
  input  logic [rcem_pkg::THR_W-1:0]   threshold,
  output logic                         ram_we,
  output logic [rcem_pkg::ADDR_W-1:0]  ram_addr,
  output logic [rcem_pkg::PIX_W-1:0]   ram_wdata,
  input  logic [rcem_pkg::PIX_W-1:0]   ram_rdata,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         is_edge,
  output logic [rcem_pkg::COORD_W-1:0] out_col,
  output logic [rcem_pkg::COORD_W-1:0] out_row
);

  rcem_pkg::back_state_t state;
  rcem_pkg::back_state_t state_next;

  logic [rcem_pkg::COORD_W-1:0]   qx;
  logic [rcem_pkg::COORD_W-1:0]   qy;
  logic [rcem_pkg::NUM_CELLS-1:0] qcells;
  logic [rcem_pkg::CNT_W-1:0]     cnt;
  logic [1:0]                     dx;
  logic [1:0]                     dy;
  logic                           rd_issued;
  logic [rcem_pkg::PIX_W-1:0]     win [rcem_pkg::WIN_SIZE];
  logic [rcem_pkg::SQ_W-1:0]      sq [rcem_pkg::NUM_SQ];
  logic [rcem_pkg::SQ_W-1:0]      sq_comb [rcem_pkg::NUM_SQ];
  logic [1:0]                     sq_cell;
  logic                           sq_valid;
  logic                           hot;
  logic [rcem_pkg::THR_W-1:0]     energy;
  logic [rcem_pkg::PIX_W-1:0]     pa;
  logic [rcem_pkg::PIX_W-1:0]     pb;
  logic [rcem_pkg::PIX_W-1:0]     pc;
  logic [rcem_pkg::PIX_W-1:0]     pd;
  logic                           fetch_issue;
  logic                           energy_issue;
  logic                           load_out;
  logic [rcem_pkg::COORD_W-1:0]   fetch_col;
  logic [rcem_pkg::COORD_W-1:0]   fetch_row;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      rcem_pkg::B_IDLE: begin
        if (q_valid && (q_head.op == rcem_pkg::OP_QUERY)) begin
          state_next = rcem_pkg::B_FETCH;
        end
      end
      rcem_pkg::B_FETCH: begin
        if (cnt == rcem_pkg::CNT_W'(rcem_pkg::WIN_SIZE)) begin
          state_next = rcem_pkg::B_ENERGY;
        end
      end
      rcem_pkg::B_ENERGY: begin
        if (cnt == rcem_pkg::CNT_W'(rcem_pkg::NUM_CELLS)) begin
          state_next = rcem_pkg::B_RESULT;
        end
      end
      rcem_pkg::B_RESULT: begin
        if (!out_valid || !out_stall) begin
          state_next = rcem_pkg::B_IDLE;
        end
      end
      default: state_next = rcem_pkg::B_IDLE;
    endcase
  end

  assign fetch_col = qx + rcem_pkg::COORD_W'(dx) - rcem_pkg::COORD_W'(1);
  assign fetch_row = qy + rcem_pkg::COORD_W'(dy) - rcem_pkg::COORD_W'(1);

  // Outputs of the state machine.
  always_comb begin
    q_pop        = 1'b0;
    ram_we       = 1'b0;
    ram_addr     = {fetch_col, fetch_row};
    ram_wdata    = q_head.pixel;
    fetch_issue  = 1'b0;
    energy_issue = 1'b0;
    load_out     = 1'b0;
    case (state)
      rcem_pkg::B_IDLE: begin
        q_pop    = q_valid;
        ram_we   = q_valid && (q_head.op == rcem_pkg::OP_WRITE);
        ram_addr = {q_head.col, q_head.row};
      end
      rcem_pkg::B_FETCH: begin
        fetch_issue = (cnt < rcem_pkg::CNT_W'(rcem_pkg::WIN_SIZE));
      end
      rcem_pkg::B_ENERGY: begin
        energy_issue = (cnt < rcem_pkg::CNT_W'(rcem_pkg::NUM_CELLS));
      end
      rcem_pkg::B_RESULT: begin
        load_out = !out_valid || !out_stall;
      end
      default: ;
    endcase
  end

  // Pixels of the cell under evaluation, taken from fixed window taps.
  // The window holds the neighborhood in column-major order from (x-1,y-1).
  always_comb begin
    case (cnt[1:0])
      2'd0: begin pa = win[0]; pb = win[4]; pc = win[3]; pd = win[1]; end
      2'd1: begin pa = win[1]; pb = win[5]; pc = win[4]; pd = win[2]; end
      2'd2: begin pa = win[3]; pb = win[7]; pc = win[6]; pd = win[4]; end
      default: begin pa = win[4]; pb = win[8]; pc = win[7]; pd = win[5]; end
    endcase
    for (int ch = 0; ch < 3; ch++) begin
      sq_comb[2*ch]   = rcem_pkg::abs_sq(pa[ch*rcem_pkg::CHAN_W +: rcem_pkg::CHAN_W],
                                         pb[ch*rcem_pkg::CHAN_W +: rcem_pkg::CHAN_W]);
      sq_comb[2*ch+1] = rcem_pkg::abs_sq(pc[ch*rcem_pkg::CHAN_W +: rcem_pkg::CHAN_W],
                                         pd[ch*rcem_pkg::CHAN_W +: rcem_pkg::CHAN_W]);
    end
  end

  always_comb begin
    energy = '0;
    for (int i = 0; i < rcem_pkg::NUM_SQ; i++) begin
      energy = energy + rcem_pkg::THR_W'(sq[i]);
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rcem_pkg::B_IDLE;
      cnt       <= '0;
      rd_issued <= 1'b0;
      sq_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rd_issued <= fetch_issue;
      sq_valid  <= energy_issue;
      if (state_next != state) begin
        cnt <= '0;
      end else begin
        cnt <= cnt + rcem_pkg::CNT_W'(1);
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (state == rcem_pkg::B_IDLE) begin
      qx     <= q_head.col;
      qy     <= q_head.row;
      qcells <= q_head.cells;
      dx     <= '0;
      dy     <= '0;
      hot    <= 1'b0;
    end else begin
      if (fetch_issue) begin
        if (dy == 2'd2) begin
          dy <= '0;
          dx <= dx + 2'd1;
        end else begin
          dy <= dy + 2'd1;
        end
      end
      // A cell outside the frame may see unwritten pixels; its mask keeps it out.
      if (sq_valid && qcells[sq_cell] && (energy > threshold)) begin
        hot <= 1'b1;
      end
    end
    if (rd_issued) begin
      for (int i = 0; i < rcem_pkg::WIN_SIZE - 1; i++) begin
        win[i] <= win[i+1];
      end
      win[rcem_pkg::WIN_SIZE-1] <= ram_rdata;
    end
    if (energy_issue) begin
      sq      <= sq_comb;
      sq_cell <= cnt[1:0];
    end
    if (load_out) begin
      is_edge <= hot;
      out_col <= qx;
      out_row <= qy;
    end
  end

endmodule

>>> src/roberts_cross_edge_marker.sv
// Channel | Direction | Handshake            | Transfer carries
// cfg     | in        | cfg_valid/cfg_ready  | cfg_index, cfg_data
// in      | in        | in_valid/in_stall    | kind, col, row, red, green, blue
// out     | out       | out_valid/out_stall  | is_edge, out_col, out_row
//
// A pixel write is done in the back end's idle state; a query runs through the
// nine reads of its 3x3 neighborhood through the single port of the frame RAM
// and the four-cell energy pass that follows. A four-entry queue lets inputs be
// taken while the back end works or a result waits. Reset clears control state
// only; the frame store holds whatever it held until it is written.
// Top level of the edge marker; depends on rcem_pkg, rcem_front, rcem_queue, rcem_back and rcem_ram.
module roberts_cross_edge_marker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rcem_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rcem_pkg::THR_W-1:0]     cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           kind,
  input  logic [rcem_pkg::COORD_W-1:0]   col,
  input  logic [rcem_pkg::COORD_W-1:0]   row,
  input  logic [rcem_pkg::CHAN_W-1:0]    red,
  input  logic [rcem_pkg::CHAN_W-1:0]    green,
  input  logic [rcem_pkg::CHAN_W-1:0]    blue,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           is_edge,
  output logic [rcem_pkg::COORD_W-1:0]   out_col,
  output logic [rcem_pkg::COORD_W-1:0]   out_row
);

  logic                         q_full;
  logic                         q_push;
  rcem_pkg::cmd_t               q_cmd;
  logic                         q_pop;
  logic                         q_valid;
  rcem_pkg::cmd_t               q_head;
  logic [rcem_pkg::THR_W-1:0]   threshold;
  logic                         ram_we;
  logic [rcem_pkg::ADDR_W-1:0]  ram_addr;
  logic [rcem_pkg::PIX_W-1:0]   ram_wdata;
  logic [rcem_pkg::PIX_W-1:0]   ram_rdata;

  rcem_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .kind      (kind),
    .col       (col),
    .row       (row),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (q_cmd),
    .threshold (threshold)
  );

  rcem_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_cmd   (q_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head       (q_head)
  );

  rcem_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .threshold (threshold),
    .ram_we    (ram_we),
    .ram_addr  (ram_addr),
    .ram_wdata (ram_wdata),
    .ram_rdata (ram_rdata),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .is_edge   (is_edge),
    .out_col   (out_col),
    .out_row   (out_row)
  );

  rcem_ram #(
    .WIDTH (rcem_pkg::PIX_W),
    .DEPTH (rcem_pkg::MEM_DEPTH)
  ) u_frame_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

endmodule

>>> src/rcem_checker.sv
// Port-level checker of the edge marker, bound to the top level.
// Depends on rcem_pkg and the assertion macros of the defines header.
`include "roberts_cross_edge_marker_defines.svh"

module rcem_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           cfg_valid,
  input logic                           cfg_ready,
  input logic [rcem_pkg::CFG_IDX_W-1:0] cfg_index,
  input logic [rcem_pkg::THR_W-1:0]     cfg_data,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           kind,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic                           is_edge,
  input logic [rcem_pkg::COORD_W-1:0]   out_col,
  input logic [rcem_pkg::COORD_W-1:0]   out_row
);

  logic [3:0]                 pending;
  logic [rcem_pkg::DIM_W-1:0] width_seen;
  logic [rcem_pkg::DIM_W-1:0] height_seen;
  logic                       query_in;
  logic                       result_out;

  assign query_in   = in_valid && !in_stall && (kind == rcem_pkg::OP_QUERY);
  assign result_out = out_valid && !out_stall;

  // Queries accepted whose result has not yet been transferred.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (query_in && !result_out) begin
      pending <= pending + 4'd1;
    end else if (result_out && !query_in) begin
      pending <= pending - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width_seen  <= rcem_pkg::DIM_W'(256);
      height_seen <= rcem_pkg::DIM_W'(256);
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == rcem_pkg::REG_FRAME_WIDTH) begin
        width_seen <= cfg_data[rcem_pkg::DIM_W-1:0];
      end
      if (cfg_index == rcem_pkg::REG_FRAME_HEIGHT) begin
        height_seen <= cfg_data[rcem_pkg::DIM_W-1:0];
      end
    end
  end

  `RCEM_ASSERT_NEXT(a_out_held, clk, rst, out_valid && out_stall, out_valid && $stable(is_edge) && $stable(out_col) && $stable(out_row), "result changed while stalled")
  `RCEM_ASSERT_IMPL(a_no_stray_result, clk, rst, out_valid, pending != 4'd0, "result without a pending query")
  `RCEM_ASSERT_IMPL(a_pending_bound, clk, rst, 1'b1, pending <= 4'(rcem_pkg::QUEUE_DEPTH + 2), "more queries in flight than the block can hold")
  `RCEM_ASSERT_IMPL(a_edge_in_frame, clk, rst, out_valid && is_edge, (rcem_pkg::DIM_W'(out_col) < width_seen) && (rcem_pkg::DIM_W'(out_row) < height_seen), "edge mark outside the frame")

endmodule

bind roberts_cross_edge_marker rcem_checker u_rcem_checker (
  .clk       (clk),
  .rst       (rst),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready),
  .cfg_index (cfg_index),
  .cfg_data  (cfg_data),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .kind      (kind),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .is_edge   (is_edge),
  .out_col   (out_col),
  .out_row   (out_row)
);

>>> dv/roberts_cross_edge_marker_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the Roberts-cross edge marker: watches the config, input and
// result channels, keeps its own frame copy and predicts each edge mark.
// Depends on rcem_pkg for widths and the register index enum.
module roberts_cross_edge_marker_checker
  import rcem_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [THR_W-1:0]     cfg_data,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic                 kind,
  input  logic [COORD_W-1:0]   col,
  input  logic [COORD_W-1:0]   row,
  input  logic [CHAN_W-1:0]    red,
  input  logic [CHAN_W-1:0]    green,
  input  logic [CHAN_W-1:0]    blue,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic                 is_edge,
  input  logic [COORD_W-1:0]   out_col,
  input  logic [COORD_W-1:0]   out_row,
  output int                   fail_count,
  output int                   marks_waiting
);

  localparam int RESET_THRESHOLD = 2000;

  typedef struct packed {
    logic               is_edge;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
  } edge_mark_t;

  edge_mark_t       pending_marks[$];
  logic [PIX_W-1:0] frame_copy [MEM_DEPTH];
  int               width_cfg;
  int               height_cfg;
  int               threshold_cfg;

  task automatic report_mismatch(input string msg);
    $display("%0t ns: MISMATCH %s", $time, msg);
    fail_count++;
  endtask

  function automatic int chan_gap_sq(input logic [CHAN_W-1:0] a, input logic [CHAN_W-1:0] b);
    int d;
    d = int'(a) - int'(b);
    return d * d;
  endfunction

  // A cell only exists when its right and lower neighbors lie inside the frame.
  function automatic bit cell_hot(input int x, input int y);
    int cols;
    int rows;
    int energy;
    logic [PIX_W-1:0] here, diag, right, below;
    cols = (width_cfg < MAX_WIDTH) ? width_cfg : MAX_WIDTH;
    rows = (height_cfg < MAX_HEIGHT) ? height_cfg : MAX_HEIGHT;
    if (x < 0 || y < 0 || x + 1 >= cols || y + 1 >= rows) return 1'b0;
    here  = frame_copy[x * MAX_HEIGHT + y];
    diag  = frame_copy[(x + 1) * MAX_HEIGHT + y + 1];
    right = frame_copy[(x + 1) * MAX_HEIGHT + y];
    below = frame_copy[x * MAX_HEIGHT + y + 1];
    energy = 0;
    for (int ch = 0; ch < 3; ch++) begin
      energy += chan_gap_sq(here[ch*CHAN_W +: CHAN_W], diag[ch*CHAN_W +: CHAN_W])
              + chan_gap_sq(right[ch*CHAN_W +: CHAN_W], below[ch*CHAN_W +: CHAN_W]);
    end
    return energy > threshold_cfg;
  endfunction

  function automatic bit edge_mark_of(input int x, input int y);
    return cell_hot(x, y) || cell_hot(x - 1, y - 1) || cell_hot(x - 1, y) ||
           cell_hot(x, y - 1);
  endfunction

  always @(posedge clk) begin
    edge_mark_t want;
    if (rst) begin
      pending_marks.delete();
      width_cfg     = MAX_WIDTH;
      height_cfg    = MAX_HEIGHT;
      threshold_cfg = RESET_THRESHOLD;
    end else begin
      // Results first: a query taken at this edge cannot answer at the same edge.
      if (out_valid && !out_stall) begin
        if (pending_marks.size() == 0) begin
          report_mismatch($sformatf("unexpected result is_edge=%0d at (%0d,%0d)",
                                    is_edge, out_col, out_row));
        end else begin
          want = pending_marks.pop_front();
          if (is_edge !== want.is_edge)
            report_mismatch($sformatf("is_edge at (%0d,%0d): got %0d, expected %0d",
                                      want.col, want.row, is_edge, want.is_edge));
          if (out_col !== want.col)
            report_mismatch($sformatf("out_col: got %0d, expected %0d", out_col, want.col));
          if (out_row !== want.row)
            report_mismatch($sformatf("out_row: got %0d, expected %0d", out_row, want.row));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (reg_idx_t'(cfg_index))
          REG_FRAME_WIDTH:    width_cfg = int'(cfg_data[DIM_W-1:0]);
          REG_FRAME_HEIGHT:   height_cfg = int'(cfg_data[DIM_W-1:0]);
          REG_EDGE_THRESHOLD: threshold_cfg = int'(cfg_data);
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        if (op_t'(kind) == OP_WRITE) begin
          frame_copy[int'(col) * MAX_HEIGHT + int'(row)] = {red, green, blue};
        end else begin
          want.is_edge = edge_mark_of(int'(col), int'(row));
          want.col     = col;
          want.row     = row;
          pending_marks = {pending_marks, want};
        end
      end
    end
    marks_waiting <= pending_marks.size();
  end

endmodule

>>> dv/roberts_cross_edge_marker_tb.sv
`timescale 1ns / 1ps
// Top of the edge marker testbench: clock, reset, config writes, pixel and
// query stimulus, receiver stalls and the verdict. Needs rcem_pkg, the block
// and roberts_cross_edge_marker_checker.
module roberts_cross_edge_marker_tb;
  import rcem_pkg::*;

  localparam int WATCHDOG_LIMIT   = 4000;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES    = 100;
  localparam int PHASE_ITEMS      = 330;
  localparam int MAX_THRESHOLD    = 390150;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [THR_W-1:0]     cfg_data  = '0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  logic                 kind      = 1'b0;
  logic [COORD_W-1:0]   col       = '0;
  logic [COORD_W-1:0]   row       = '0;
  logic [CHAN_W-1:0]    red       = '0;
  logic [CHAN_W-1:0]    green     = '0;
  logic [CHAN_W-1:0]    blue      = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 is_edge;
  logic [COORD_W-1:0]   out_col;
  logic [COORD_W-1:0]   out_row;

  int               fail_count;
  int               marks_waiting;
  int               tx_gap_pct   = 0;
  int               rx_stall_pct = 0;
  bit               long_hold_go = 1'b0;
  int               hold_count   = 0;
  int               quiet_cycles = 0;
  int               items_sent   = 0;
  bit               pixel_written [MEM_DEPTH];
  logic [PIX_W-1:0] base_rgb     = '0;
  int               smooth_pct   = 0;

  roberts_cross_edge_marker dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .kind(kind), .col(col), .row(row),
    .red(red), .green(green), .blue(blue),
    .out_valid(out_valid), .out_stall(out_stall), .is_edge(is_edge),
    .out_col(out_col), .out_row(out_row)
  );

  roberts_cross_edge_marker_checker u_checker (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .kind(kind), .col(col), .row(row),
    .red(red), .green(green), .blue(blue),
    .out_valid(out_valid), .out_stall(out_stall), .is_edge(is_edge),
    .out_col(out_col), .out_row(out_row),
    .fail_count(fail_count), .marks_waiting(marks_waiting)
  );

  always #1 clk = ~clk;

  // Result side: one long hold-off when requested, random stalls otherwise.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (long_hold_go && hold_count < LONG_HOLD_CYCLES) begin
      out_stall <= 1'b1;
      hold_count++;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Often colors close to the phase base, so energies land near the threshold.
  function automatic logic [PIX_W-1:0] pick_color();
    if ($urandom_range(0, 99) >= smooth_pct) return PIX_W'($urandom);
    if ($urandom_range(0, 1) == 0) return base_rgb ^ (PIX_W'($urandom) & 24'h030303);
    return base_rgb ^ (PIX_W'($urandom) & 24'h1F1F1F);
  endfunction

  // valid stays high from one transfer to the next unless a gap is drawn.
  task automatic send_item(input op_t op, input int x, input int y,
                           input logic [PIX_W-1:0] rgb);
    while ($urandom_range(0, 99) < tx_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    kind     <= op;
    col      <= COORD_W'(x);
    row      <= COORD_W'(y);
    {red, green, blue} <= rgb;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic put_pixel(input int x, input int y, input logic [PIX_W-1:0] rgb);
    pixel_written[x * MAX_HEIGHT + y] = 1'b1;
    send_item(OP_WRITE, x, y, rgb);
  endtask

  // The 3x3 neighbors in the store go first; in-frame cells read no empty entry.
  task automatic ask_pixel(input int x, input int y);
    for (int nx = x - 1; nx <= x + 1; nx++) begin
      for (int ny = y - 1; ny <= y + 1; ny++) begin
        if (nx >= 0 && nx < MAX_WIDTH && ny >= 0 && ny < MAX_HEIGHT &&
            !pixel_written[nx * MAX_HEIGHT + ny])
          put_pixel(nx, ny, pick_color());
      end
    end
    send_item(OP_QUERY, x, y, PIX_W'($urandom));
  endtask

  task automatic write_reg(input reg_idx_t idx, input int value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= THR_W'(value);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_frame(input int w, input int h, input int thr);
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
    write_reg(REG_EDGE_THRESHOLD, thr);
    cfg_valid <= 1'b0;
  endtask

  // Writes give no result, so a fixed pause follows the last expected mark.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (marks_waiting != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input int w, input int h, input int thr, input int gap,
                           input int stall, input bit hold);
    int cols, rows, span_c, span_r, wx, wy, target, pick;
    settle();
    set_frame(w, h, thr);
    tx_gap_pct   = gap;
    rx_stall_pct = stall;
    base_rgb     = PIX_W'($urandom);
    smooth_pct   = $urandom_range(30, 80);
    cols   = (w < MAX_WIDTH) ? w : MAX_WIDTH;
    rows   = (h < MAX_HEIGHT) ? h : MAX_HEIGHT;
    span_c = (cols + 1 < 12) ? cols + 1 : 12;
    span_r = (rows + 1 < 12) ? rows + 1 : 12;
    wx     = $urandom_range(0, cols + 1 - span_c);
    wy     = $urandom_range(0, rows + 1 - span_r);
    if (hold) long_hold_go <= 1'b1;
    target = items_sent + PHASE_ITEMS;
    while (items_sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        ask_pixel((wx + $urandom_range(0, span_c - 1)) % MAX_WIDTH,
                  (wy + $urandom_range(0, span_r - 1)) % MAX_HEIGHT);
      end else if (pick < 75) begin
        put_pixel((wx + $urandom_range(0, span_c - 1)) % MAX_WIDTH,
                  (wy + $urandom_range(0, span_r - 1)) % MAX_HEIGHT, pick_color());
      end else if (pick < 85) begin
        put_pixel($urandom_range(0, 255), $urandom_range(0, 255), PIX_W'($urandom));
      end else begin
        ask_pixel($urandom_range(0, 255), $urandom_range(0, 255));
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // One cell at full contrast: its energy equals the top threshold exactly.
    set_frame(2, 2, MAX_THRESHOLD);
    put_pixel(0, 0, 24'h000000);
    put_pixel(1, 1, 24'hFFFFFF);
    put_pixel(1, 0, 24'h000000);
    put_pixel(0, 1, 24'hFFFFFF);
    ask_pixel(0, 0);
    ask_pixel(1, 1);
    ask_pixel(255, 255);
    settle();
    set_frame(2, 2, MAX_THRESHOLD - 1);
    ask_pixel(1, 0);
    ask_pixel(0, 1);
    settle();
    // Too narrow for any cell, with a height far beyond the store.
    set_frame(0, 511, 0);
    ask_pixel(1, 1);
    settle();
    // Width beyond the store is clipped, so the last column still has cells.
    set_frame(511, 2, 0);
    ask_pixel(255, 0);

    run_phase(16, 16, 2000, 0, 0, 1'b0);
    run_phase(256, 2, $urandom_range(0, 6000), 51, 0, 1'b0);
    run_phase(2, 256, $urandom_range(0, 100), 0, 51, 1'b0);
    run_phase($urandom_range(2, 256), $urandom_range(2, 256),
              $urandom_range(0, MAX_THRESHOLD), 9, 9, 1'b0);
    run_phase(8, 8, $urandom_range(0, 3000), 0, 0, 1'b1);
    run_phase($urandom_range(257, 511), $urandom_range(2, 40),
              $urandom_range(0, 20000), 51, 0, 1'b0);
    settle();

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> roberts_cross_edge_marker.f
+incdir+src
src/rcem_pkg.sv
src/rcem_ram.sv
src/rcem_front.sv
src/rcem_queue.sv
src/rcem_back.sv
src/roberts_cross_edge_marker.sv
src/rcem_checker.sv
dv/roberts_cross_edge_marker_checker.sv
dv/roberts_cross_edge_marker_tb.sv
